// ===== src/polyline_even_spacing_sampler_macros.svh =====
// assertion macros for the polyline dot sampler
// expects clk and arst_n in the scope of the module that uses them
`ifndef POLYLINE_EVEN_SPACING_SAMPLER_MACROS_SVH
`define POLYLINE_EVEN_SPACING_SAMPLER_MACROS_SVH

// same-cycle implication
`define PESS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PESS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pess_pkg.sv =====
// shared types, constants and the arctangent table of the polyline dot sampler
// no dependencies
package pess_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = 33;
	localparam int LEN_W     = 33;
	localparam int PROD_W    = 66;
	localparam int SPACING_W = 24;
	localparam int YAW_W     = 16;
	localparam int ANG_W     = 32;
	localparam int CORD_W    = 36;
	localparam int CSTEP_W   = 5;
	localparam int CORDIC_STEPS = 30;

	localparam logic [SPACING_W-1:0] SPACING_RESET = 24'd25600;

	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT,
		ST_CHECK,
		ST_REM,
		ST_PROD,
		ST_LAUNCH,
		ST_DIV,
		ST_EMIT,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic  in_ready;
		logic  start_path;
		logic  load_seg;
		logic  mul;
		logic  mul_dot;
		axis_t sel;
		logic  root_start;
		logic  check;
		logic  div_start;
		logic  rem_mode;
		logic  rem_take;
		logic  emit;
		logic  last;
		logic  commit;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic first;
		logic sqrt_busy;
		logic cordic_busy;
		logic div_busy;
		logic need;
		logic step_past;
		logic out_free;
	} status_t;

	// atan(2^-i) on a 2^32-per-turn angle
	function automatic logic [ANG_W-1:0] atan_lut(input logic [CSTEP_W-1:0] idx);
		logic [ANG_W-1:0] v;
		case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41721;
			5'd15: v = 32'd20860;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2607;
			5'd19: v = 32'd1303;
			5'd20: v = 32'd651;
			5'd21: v = 32'd325;
			5'd22: v = 32'd162;
			5'd23: v = 32'd81;
			5'd24: v = 32'd40;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd2;
			5'd29: v = 32'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/pess_point_if.sv =====
// input channel: one polyline point per transaction
// depends on pess_pkg
interface pess_point_if;
	logic valid;
	logic ready;
	logic signed [pess_pkg::COORD_W-1:0] point_x;
	logic signed [pess_pkg::COORD_W-1:0] point_y;
	logic signed [pess_pkg::COORD_W-1:0] point_z;
	logic first_point;

	modport source(output valid, point_x, point_y, point_z, first_point, input ready);
	modport sink(input valid, point_x, point_y, point_z, first_point, output ready);
endinterface

// ===== src/pess_dot_if.sv =====
// output channel: one marker dot per transaction
// depends on pess_pkg
interface pess_dot_if;
	logic valid;
	logic ready;
	logic signed [pess_pkg::COORD_W-1:0] dot_x;
	logic signed [pess_pkg::COORD_W-1:0] dot_y;
	logic signed [pess_pkg::COORD_W-1:0] dot_z;
	logic signed [pess_pkg::YAW_W-1:0] dot_yaw;
	logic segment_last;
	logic dots_dropped;

	modport source(output valid, dot_x, dot_y, dot_z, dot_yaw, segment_last, dots_dropped,
		input ready);
	modport sink(input valid, dot_x, dot_y, dot_z, dot_yaw, segment_last, dots_dropped,
		output ready);
endinterface

// ===== src/pess_div.sv =====
// restoring divider, one quotient bit per cycle
// the upper half of the numerator must be below the divisor; depends on pess_pkg
module pess_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [pess_pkg::PROD_W-1:0] num,
	input  logic [pess_pkg::LEN_W-1:0]  den,
	output logic busy,
	output logic [pess_pkg::LEN_W-1:0]  quo,
	output logic [pess_pkg::LEN_W-1:0]  rem
);
	import pess_pkg::*;

	logic [LEN_W-1:0] rem_q, low_q, quo_q, den_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic [LEN_W:0]   cand, diff;
	logic             ge;

	assign cand = {rem_q, low_q[LEN_W-1]};
	assign ge   = cand >= {1'b0, den_q};
	assign diff = cand - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(LEN_W-1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[PROD_W-1:LEN_W];
			low_q <= num[LEN_W-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LEN_W-1:0] : cand[LEN_W-1:0];
			low_q <= {low_q[LEN_W-2:0], 1'b0};
			quo_q <= {quo_q[LEN_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

// ===== src/pess_sqrt.sv =====
// digit-by-digit integer square root (floor), one root bit per cycle
// depends on pess_pkg
module pess_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [pess_pkg::PROD_W-1:0] rad,
	output logic busy,
	output logic [pess_pkg::LEN_W-1:0]  root
);
	import pess_pkg::*;

	logic [PROD_W-1:0] rad_q;
	logic [LEN_W+1:0]  rem_q;
	logic [LEN_W-1:0]  root_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic [LEN_W+3:0]  cand, trial;
	logic              ge;

	assign cand  = {rem_q, rad_q[PROD_W-1:PROD_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = cand >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(LEN_W-1))
				busy_q <= 1'b0;
		end
	end

	// partial remainder reaches twice the root, so it keeps two bits over the root width
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[PROD_W-3:0], 2'b00};
			rem_q  <= ge ? (LEN_W+2)'(cand - trial) : (LEN_W+2)'(cand);
			root_q <= {root_q[LEN_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

// ===== src/pess_cordic.sv =====
// vectoring cordic for the segment heading, 30 iterations, rounded to 16 bits
// depends on pess_pkg for widths and the arctangent table
module pess_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [pess_pkg::DIFF_W-1:0] dx,
	input  logic signed [pess_pkg::DIFF_W-1:0] dy,
	output logic busy,
	output logic signed [pess_pkg::YAW_W-1:0]  yaw
);
	import pess_pkg::*;

	logic signed [CORD_W-1:0] x_q, y_q, xs, ys, dx_w, dy_w;
	logic [ANG_W-1:0]   ang_q, ang_rnd;
	logic [CSTEP_W-1:0] i_q;
	logic               busy_q, zero_q;

	assign dx_w = CORD_W'(dx);
	assign dy_w = CORD_W'(dy);
	assign xs   = x_q >>> i_q;
	assign ys   = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 5'd1;
			if (i_q == CSTEP_W'(CORDIC_STEPS-1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == '0) && (dy == '0);
			// left half-plane: rotate by half a turn first
			x_q    <= dx[DIFF_W-1] ? -dx_w : dx_w;
			y_q    <= dx[DIFF_W-1] ? -dy_w : dy_w;
			ang_q  <= dx[DIFF_W-1] ? 32'h8000_0000 : '0;
		end else if (busy_q) begin
			if (!y_q[CORD_W-1]) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				ang_q <= ang_q + atan_lut(i_q);
			end else begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				ang_q <= ang_q - atan_lut(i_q);
			end
		end
	end

	assign ang_rnd = ang_q + 32'h0000_8000;
	assign yaw     = zero_q ? '0 : $signed(ang_rnd[ANG_W-1:ANG_W-YAW_W]);
	assign busy    = busy_q;
endmodule

// ===== src/pess_dp.sv =====
// datapath: path state, shared multiplier, root, heading, dividers and dot register
// depends on pess_pkg, pess_point_if, pess_dot_if, pess_div, pess_sqrt, pess_cordic
module pess_dp #(
	parameter int MAX_DOTS_PER_SEGMENT = 64,
	parameter int FRACTION_BITS        = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [pess_pkg::SPACING_W-1:0] cfg_wdata,
	pess_point_if.sink point,
	pess_dot_if.source dot,
	input  pess_pkg::cmd_t    cmd,
	output pess_pkg::status_t sts
);
	import pess_pkg::*;

	localparam logic signed [DIFF_W:0] LIFT = (DIFF_W+1)'(5) <<< FRACTION_BITS;
	localparam logic signed [DIFF_W:0] ZMAX = 34'sd2147483647;

	logic [SPACING_W-1:0] spacing_q, s_eff;
	logic have_prev_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q, prev_z_q, pt_x_q, pt_y_q, pt_z_q;
	logic signed [DIFF_W-1:0]  dx_q, dy_q, dz_q;
	logic [LEN_W-1:0]  carried_q, cnext_q, len, rem_num;
	logic [LEN_W:0]    dcur_q, cap;
	logic              dropped_q, out_valid_q;
	logic [PROD_W-1:0] nx_q, ny_q, nz_q, prod, rad, num_x;
	logic [LEN_W-1:0]  mul_a, mul_b, den_x, qx, qy, qz, rx, ry_unused, rz_unused;
	logic              bx, by, bz;
	logic signed [YAW_W-1:0]  yaw;
	logic signed [DIFF_W:0]   lx, ly, lz, zz;

	function automatic logic [LEN_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
		return v[DIFF_W-1] ? LEN_W'(-v) : LEN_W'(v);
	endfunction

	function automatic logic signed [DIFF_W:0] lerp(input logic signed [COORD_W-1:0] st,
			input logic neg, input logic [LEN_W-1:0] q);
		logic signed [DIFF_W:0] s34, q34;
		s34 = (DIFF_W+1)'(st);
		q34 = $signed({1'b0, q});
		return neg ? s34 - q34 : s34 + q34;
	endfunction

	assign s_eff = (spacing_q == '0) ? SPACING_W'(1) : spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			spacing_q <= SPACING_RESET;
		else if (cfg_we)
			spacing_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			have_prev_q <= 1'b0;
		else if (cmd.start_path)
			have_prev_q <= 1'b1;
	end

	// shared multiplier: squares of the deltas, then delta times distance per dot
	always_comb begin
		case (cmd.sel)
			AXIS_X:  mul_a = mag(dx_q);
			AXIS_Y:  mul_a = mag(dy_q);
			AXIS_Z:  mul_a = mag(dz_q);
			default: mul_a = '0;
		endcase
	end
	assign mul_b = cmd.mul_dot ? dcur_q[LEN_W-1:0] : mul_a;
	assign prod  = mul_a * mul_b;
	assign rad   = nx_q + ny_q + nz_q;

	assign cap     = (LEN_W+1)'(s_eff) * (LEN_W+1)'(MAX_DOTS_PER_SEGMENT);
	assign rem_num = len - carried_q - 33'd1;
	assign num_x   = cmd.rem_mode ? PROD_W'(rem_num) : nx_q;
	assign den_x   = cmd.rem_mode ? LEN_W'(s_eff) : len;

	always_ff @(posedge clk) begin
		if (cmd.start_path) begin
			prev_x_q  <= point.point_x;
			prev_y_q  <= point.point_y;
			prev_z_q  <= point.point_z;
			carried_q <= LEN_W'(s_eff);
		end else if (cmd.commit) begin
			prev_x_q  <= pt_x_q;
			prev_y_q  <= pt_y_q;
			prev_z_q  <= pt_z_q;
			carried_q <= cnext_q;
		end
		if (cmd.load_seg) begin
			pt_x_q <= point.point_x;
			pt_y_q <= point.point_y;
			pt_z_q <= point.point_z;
			dx_q   <= DIFF_W'(point.point_x) - DIFF_W'(prev_x_q);
			dy_q   <= DIFF_W'(point.point_y) - DIFF_W'(prev_y_q);
			dz_q   <= DIFF_W'(point.point_z) - DIFF_W'(prev_z_q);
		end
		if (cmd.mul) begin
			case (cmd.sel)
				AXIS_X:  nx_q <= prod;
				AXIS_Y:  ny_q <= prod;
				AXIS_Z:  nz_q <= prod;
				default: ;
			endcase
		end
		if (cmd.check) begin
			dcur_q    <= {1'b0, carried_q};
			cnext_q   <= carried_q - len;
			dropped_q <= ({1'b0, carried_q} + cap) < {1'b0, len};
		end else if (cmd.emit) begin
			dcur_q <= dcur_q + (LEN_W+1)'(s_eff);
		end
		// next carried distance lands on the spacing grid just past the segment end
		if (cmd.rem_take)
			cnext_q <= LEN_W'(s_eff) - 33'd1 - rx;
	end

	pess_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.root_start), .rad(rad),
		.busy(sts.sqrt_busy), .root(len)
	);

	pess_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cmd.root_start), .dx(dx_q), .dy(dy_q),
		.busy(sts.cordic_busy), .yaw(yaw)
	);

	pess_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(num_x), .den(den_x),
		.busy(bx), .quo(qx), .rem(rx)
	);

	pess_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start && !cmd.rem_mode), .num(ny_q),
		.den(len), .busy(by), .quo(qy), .rem(ry_unused)
	);

	pess_div u_div_z (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start && !cmd.rem_mode), .num(nz_q),
		.den(len), .busy(bz), .quo(qz), .rem(rz_unused)
	);

	assign lx = lerp(prev_x_q, dx_q[DIFF_W-1], qx);
	assign ly = lerp(prev_y_q, dy_q[DIFF_W-1], qy);
	assign lz = lerp(prev_z_q, dz_q[DIFF_W-1], qz);
	assign zz = lz + LIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (dot.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			dot.dot_x        <= lx[COORD_W-1:0];
			dot.dot_y        <= ly[COORD_W-1:0];
			dot.dot_z        <= (zz > ZMAX) ? ZMAX[COORD_W-1:0] : zz[COORD_W-1:0];
			dot.dot_yaw      <= yaw;
			dot.segment_last <= cmd.last;
			dot.dots_dropped <= dropped_q;
		end
	end

	assign dot.valid   = out_valid_q;
	assign point.ready = cmd.in_ready;

	assign sts.in_valid  = point.valid;
	assign sts.first     = point.first_point || !have_prev_q;
	assign sts.div_busy  = bx || by || bz || (|ry_unused & 1'b0) || (|rz_unused & 1'b0);
	assign sts.need      = carried_q < len;
	assign sts.step_past = (dcur_q + (LEN_W+1)'(s_eff)) >= {1'b0, len};
	assign sts.out_free  = !out_valid_q || dot.ready;
endmodule

// ===== src/pess_ctrl.sv =====
// controller state machine: sequences squares, root, remainder and the dot loop
// depends on pess_pkg and the assertion macro header
`include "polyline_even_spacing_sampler_macros.svh"
module pess_ctrl #(
	parameter int MAX_DOTS_PER_SEGMENT = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  pess_pkg::status_t sts,
	output pess_pkg::cmd_t    cmd
);
	import pess_pkg::*;

	localparam int CW = $clog2(MAX_DOTS_PER_SEGMENT + 1);

	state_t        st_q, st_d;
	axis_t         sel_q;
	logic [CW-1:0] cnt_q;
	logic          cnt_last;

	assign cnt_last = cnt_q == CW'(MAX_DOTS_PER_SEGMENT - 1);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:   if (sts.in_valid && !sts.first) st_d = ST_SQUARE;
			ST_SQUARE: if (sel_q == AXIS_Z) st_d = ST_SUM;
			ST_SUM:    st_d = ST_ROOT;
			ST_ROOT:   if (!sts.sqrt_busy && !sts.cordic_busy) st_d = ST_CHECK;
			ST_CHECK:  st_d = sts.need ? ST_REM : ST_COMMIT;
			ST_REM:    if (!sts.div_busy) st_d = ST_PROD;
			ST_PROD:   if (sel_q == AXIS_Z) st_d = ST_LAUNCH;
			ST_LAUNCH: st_d = ST_DIV;
			ST_DIV:    if (!sts.div_busy) st_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free)
					st_d = (sts.step_past || cnt_last) ? ST_COMMIT : ST_PROD;
			end
			ST_COMMIT: st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '0;
		cmd.sel = sel_q;
		case (st_q)
			ST_IDLE: begin
				cmd.in_ready   = 1'b1;
				cmd.start_path = sts.in_valid && sts.first;
				cmd.load_seg   = sts.in_valid && !sts.first;
			end
			ST_SQUARE: cmd.mul = 1'b1;
			ST_SUM:    cmd.root_start = 1'b1;
			ST_ROOT:   ;
			ST_CHECK: begin
				cmd.check     = 1'b1;
				cmd.div_start = sts.need;
				cmd.rem_mode  = 1'b1;
			end
			ST_REM: begin
				cmd.rem_mode = 1'b1;
				cmd.rem_take = !sts.div_busy;
			end
			ST_PROD: begin
				cmd.mul     = 1'b1;
				cmd.mul_dot = 1'b1;
			end
			ST_LAUNCH: cmd.div_start = 1'b1;
			ST_DIV:    ;
			ST_EMIT: begin
				cmd.emit = sts.out_free;
				cmd.last = sts.step_past || cnt_last;
			end
			ST_COMMIT: cmd.commit = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			sel_q <= AXIS_X;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if ((st_q == ST_SQUARE || st_q == ST_PROD) && sel_q != AXIS_Z)
				sel_q <= sel_q + 2'd1;
			else
				sel_q <= AXIS_X;
			if (cmd.check)
				cnt_q <= '0;
			else if (cmd.emit)
				cnt_q <= cnt_q + CW'(1);
		end
	end

	`PESS_ASSERT_NXT(a_last_commits, cmd.emit && cmd.last, st_q == ST_COMMIT, "last dot not followed by commit")
	`PESS_ASSERT_IMP(a_div_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")
	`PESS_ASSERT_IMP(a_root_idle, cmd.root_start, !sts.sqrt_busy && !sts.cordic_busy, "root or heading restarted while busy")
endmodule

// ===== src/polyline_even_spacing_sampler.sv =====
// a path's first point only starts the path; a later point runs the squares, the 33-step
// root (heading cordic in parallel) and the check, then the remainder division when the
// segment gets dots, then a product and the 33-step dividers for each dot
// one point at a time: a new point is taken only when the controller is idle
// the output register lets the next point in while the last dot waits
// reset: arst_n clears the path (next point starts a new path) and sets spacing to 25600
module polyline_even_spacing_sampler #(
	parameter int MAX_DOTS_PER_SEGMENT = 64,
	parameter int FRACTION_BITS        = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [pess_pkg::SPACING_W-1:0] cfg_wdata,
	pess_point_if.sink point,
	pess_dot_if.source dot
);
	import pess_pkg::*;

	cmd_t    cmd;
	status_t sts;

	pess_ctrl #(
		.MAX_DOTS_PER_SEGMENT(MAX_DOTS_PER_SEGMENT)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd)
	);

	pess_dp #(
		.MAX_DOTS_PER_SEGMENT(MAX_DOTS_PER_SEGMENT),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.point(point), .dot(dot), .cmd(cmd), .sts(sts)
	);
endmodule
